// ===== sv/ctcgd_pkg.sv =====
// ----------------------------------------------------------------------------
// CTC greedy decoder package
// Shared types, constants and helpers for the decoder, its controller,
// its datapath and the mean divider.
// ----------------------------------------------------------------------------
package ctcgd_pkg;

  localparam int unsigned SCORE_W = 16;
  localparam int unsigned CLASS_W = 13;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned SUM_W   = 23;

  localparam int unsigned NUM_CLASSES_DEF = 8192;
  localparam int unsigned MAX_STEPS_DEF   = 128;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // one quotient bit per cycle
  localparam int unsigned DIV_STEPS = SUM_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic REC_CHAR    = 1'b0;
  localparam logic REC_SUMMARY = 1'b1;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [CLASS_W-1:0] class_index;
    logic               end_of_step;
    logic               end_of_sequence;
  } in_item_t;

  typedef struct packed {
    logic               record_kind;
    logic [CLASS_W-1:0] char_index;
    logic [SCORE_W-1:0] prob_value;
    logic [COUNT_W-1:0] char_count;
    logic               overflow;
    logic               last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic step;
    logic load_char;
    logic div_step;
    logic load_sum;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic char_emit;
    logic seq_end;
    logic div_last;
  } sts_t;

  // Last class position a timestep may reach.
  function automatic logic [CLASS_W-1:0] pos_limit(input int unsigned num_classes);
    int unsigned n;
    n = (num_classes > 8192) ? 8192 : num_classes;
    return CLASS_W'(n - 1);
  endfunction

  // Ceiling of the per-sequence character count.
  function automatic logic [COUNT_W-1:0] count_cap(input int unsigned max_steps);
    int unsigned n;
    n = (max_steps > 255) ? 255 : max_steps;
    return COUNT_W'(n);
  endfunction

endpackage

// ===== sv/ctcgd_divider.sv =====
// ----------------------------------------------------------------------------
// CTC greedy decoder mean divider
// Restoring divider, one quotient bit per cycle while step is high, sum over character count.
// ----------------------------------------------------------------------------
module ctcgd_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            step,
  input  logic [ctcgd_pkg::SUM_W-1:0]     dividend,
  input  logic [ctcgd_pkg::COUNT_W-1:0]   divisor,
  output logic [ctcgd_pkg::SUM_W-1:0]     quotient,
  output logic                            last
);

  logic [ctcgd_pkg::DIV_CNT_W-1:0] cnt;
  logic [ctcgd_pkg::SUM_W-1:0]     dvd;
  logic [ctcgd_pkg::COUNT_W-1:0]   dvs;
  logic [ctcgd_pkg::COUNT_W-1:0]   rem;
  logic [ctcgd_pkg::COUNT_W:0]     rem_shift;
  logic [ctcgd_pkg::COUNT_W:0]     rem_sub;
  logic                            ge;

  always_comb begin
    rem_shift = {rem, dvd[ctcgd_pkg::SUM_W-1]};
    rem_sub   = rem_shift - {1'b0, dvs};
    ge        = (rem_shift >= {1'b0, dvs});
  end

  assign quotient = dvd;
  assign last     = (cnt == ctcgd_pkg::DIV_CNT_W'(ctcgd_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= '0;
    end else if (step) begin
      cnt <= cnt + ctcgd_pkg::DIV_CNT_W'(1);
    end
  end

  // shift dividend bits out and quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (step) begin
      dvd <= {dvd[ctcgd_pkg::SUM_W-2:0], ge};
      rem <= ge ? rem_sub[ctcgd_pkg::COUNT_W-1:0] : rem_shift[ctcgd_pkg::COUNT_W-1:0];
    end
  end

endmodule

// ===== sv/ctcgd_datapath.sv =====
// ----------------------------------------------------------------------------
// CTC greedy decoder datapath
// Argmax tracking, blank and repeat removal, running sum and count,
// mode register, mean divider and the output register.
// ----------------------------------------------------------------------------
module ctcgd_datapath #(
  parameter int unsigned NUM_CLASSES = ctcgd_pkg::NUM_CLASSES_DEF,
  parameter int unsigned MAX_STEPS   = ctcgd_pkg::MAX_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  ctcgd_pkg::in_item_t  in_data,
  input  ctcgd_pkg::cmd_t      cmd,
  output ctcgd_pkg::sts_t      sts,
  output ctcgd_pkg::out_item_t out_data
);

  localparam logic [ctcgd_pkg::CLASS_W-1:0] PosLimit = ctcgd_pkg::pos_limit(NUM_CLASSES);
  localparam logic [ctcgd_pkg::COUNT_W-1:0] CountCap = ctcgd_pkg::count_cap(MAX_STEPS);

  logic                            argmax_enable;
  logic [ctcgd_pkg::SCORE_W-1:0]   best_score, best_score_next;
  logic [ctcgd_pkg::CLASS_W-1:0]   best_class, best_class_next;
  logic [ctcgd_pkg::CLASS_W-1:0]   class_position, class_position_next;
  logic                            step_open, step_open_next;
  logic [ctcgd_pkg::CLASS_W-1:0]   previous_class, previous_class_next;
  logic                            first_step, first_step_next;
  logic [ctcgd_pkg::SUM_W-1:0]     prob_sum, prob_sum_next;
  logic [ctcgd_pkg::COUNT_W-1:0]   emit_count, emit_count_next;
  logic                            overflow_seen, overflow_seen_next;

  logic                            closed;
  logic                            drop;
  logic                            emit;
  logic [ctcgd_pkg::CLASS_W-1:0]   cls;
  logic [ctcgd_pkg::SCORE_W-1:0]   prob;
  logic [ctcgd_pkg::SUM_W:0]       sum_wide;

  logic [ctcgd_pkg::COUNT_W-1:0]   summ_count;
  logic                            summ_ovf;
  logic [ctcgd_pkg::SUM_W-1:0]     quotient;
  logic                            div_last;
  logic [ctcgd_pkg::SCORE_W-1:0]   mean;

  always_comb begin
    best_score_next     = best_score;
    best_class_next     = best_class;
    class_position_next = class_position;
    step_open_next      = step_open;
    previous_class_next = previous_class;
    first_step_next     = first_step;
    prob_sum_next       = prob_sum;
    emit_count_next     = emit_count;
    overflow_seen_next  = overflow_seen;
    closed              = 1'b0;
    emit                = 1'b0;
    cls                 = '0;
    prob                = '0;

    if (argmax_enable) begin
      if (!step_open) begin
        class_position_next = '0;
        best_score_next     = in_data.score;
        best_class_next     = '0;
        step_open_next      = 1'b1;
      end else if (class_position < PosLimit) begin
        class_position_next = class_position + ctcgd_pkg::CLASS_W'(1);
        // first maximum wins
        if (in_data.score > best_score) begin
          best_score_next = in_data.score;
          best_class_next = class_position_next;
        end
      end
      if (in_data.end_of_step || in_data.end_of_sequence) begin
        cls                 = best_class_next;
        prob                = best_score_next;
        closed              = 1'b1;
        step_open_next      = 1'b0;
        best_score_next     = '0;
        best_class_next     = '0;
        class_position_next = '0;
      end
    end else begin
      cls    = in_data.class_index;
      prob   = in_data.score;
      closed = 1'b1;
    end

    drop     = (cls == '0) || (!first_step && (cls == previous_class));
    sum_wide = {1'b0, prob_sum} + (ctcgd_pkg::SUM_W + 1)'(prob);

    if (closed) begin
      previous_class_next = cls;
      first_step_next     = 1'b0;
      if (!drop) begin
        emit = 1'b1;
        if (emit_count >= CountCap) begin
          overflow_seen_next = 1'b1;
        end else begin
          emit_count_next = emit_count + ctcgd_pkg::COUNT_W'(1);
          if (sum_wide > {1'b0, ctcgd_pkg::SUM_MAX}) begin
            prob_sum_next      = ctcgd_pkg::SUM_MAX;
            overflow_seen_next = 1'b1;
          end else begin
            prob_sum_next = sum_wide[ctcgd_pkg::SUM_W-1:0];
          end
        end
      end
    end
  end

  always_comb begin
    sts.char_emit = emit;
    sts.seq_end   = in_data.end_of_sequence;
    sts.div_last  = div_last;
  end

  ctcgd_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.step && in_data.end_of_sequence),
    .step     (cmd.div_step),
    .dividend (prob_sum_next),
    .divisor  (emit_count_next),
    .quotient (quotient),
    .last     (div_last)
  );

  // empty sequence gives a zero mean; clamp to Q0.16 full scale
  always_comb begin
    if (summ_count == '0) begin
      mean = '0;
    end else if (|quotient[ctcgd_pkg::SUM_W-1:ctcgd_pkg::SCORE_W]) begin
      mean = {ctcgd_pkg::SCORE_W{1'b1}};
    end else begin
      mean = quotient[ctcgd_pkg::SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      argmax_enable  <= 1'b0;
      best_score     <= '0;
      best_class     <= '0;
      class_position <= '0;
      step_open      <= 1'b0;
      previous_class <= '0;
      first_step     <= 1'b1;
      prob_sum       <= '0;
      emit_count     <= '0;
      overflow_seen  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        argmax_enable <= cfg_wr_data;
      end
      if (cmd.step) begin
        best_score     <= best_score_next;
        best_class     <= best_class_next;
        class_position <= class_position_next;
        step_open      <= step_open_next;
        if (in_data.end_of_sequence) begin
          // clear the sequence once its totals are in the summary path
          previous_class <= '0;
          first_step     <= 1'b1;
          prob_sum       <= '0;
          emit_count     <= '0;
          overflow_seen  <= 1'b0;
        end else begin
          previous_class <= previous_class_next;
          first_step     <= first_step_next;
          prob_sum       <= prob_sum_next;
          emit_count     <= emit_count_next;
          overflow_seen  <= overflow_seen_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && in_data.end_of_sequence) begin
      summ_count <= emit_count_next;
      summ_ovf   <= overflow_seen_next;
    end
    if (cmd.load_char) begin
      out_data.record_kind <= ctcgd_pkg::REC_CHAR;
      out_data.char_index  <= cls;
      out_data.prob_value  <= prob;
      out_data.char_count  <= emit_count_next;
      out_data.overflow    <= overflow_seen_next;
      out_data.last        <= !in_data.end_of_sequence;
    end else if (cmd.load_sum) begin
      out_data.record_kind <= ctcgd_pkg::REC_SUMMARY;
      out_data.char_index  <= '0;
      out_data.prob_value  <= mean;
      out_data.char_count  <= summ_count;
      out_data.overflow    <= summ_ovf;
      out_data.last        <= 1'b1;
    end
  end

endmodule

// ===== sv/ctcgd_ctrl.sv =====
// ----------------------------------------------------------------------------
// CTC greedy decoder controller
// Input and output handshakes, divider sequencing and summary hand-off.
// ----------------------------------------------------------------------------
module ctcgd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  ctcgd_pkg::sts_t sts,
  output ctcgd_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_SUM  = 3'b100
  } state_t;

  state_t state, state_next;
  logic   slot_free;
  logic   accept;
  logic   out_valid_next;

  always_comb begin
    slot_free = !out_valid || out_ready;
    in_ready  = (state == S_IDLE) && slot_free;
    accept    = in_valid && in_ready;

    cmd.step      = accept;
    cmd.load_char = accept && sts.char_emit;
    cmd.div_step  = (state == S_DIV);
    cmd.load_sum  = (state == S_SUM) && slot_free;

    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && sts.seq_end) state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.div_last) state_next = S_SUM;
      end
      S_SUM: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase

    if (cmd.load_char || cmd.load_sum) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== sv/ctc_greedy_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// CTC greedy decoder
// Greedy CTC decoding of a score stream: argmax per timestep or direct
// class input, blank and repeat removal, character records and a
// per-sequence summary carrying the truncated mean probability.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              transaction
//   --------  ---------  ---------------------  ---------------------------------
//   cfg       in         cfg_wr_en              argmax_enable write, no wait
//   in        in         in_valid / in_ready    one score or one timestep
//   out       out        out_valid / out_ready  character or summary record
//
// An input transaction without end_of_sequence leaves the controller idle, and the next
// one is taken while the output register drains. An end_of_sequence transaction runs
// the restoring divider (one quotient bit a cycle), then loads the summary once the
// output slot is free; only then is the next input taken. A record waiting at the
// output holds the input until taken.
// Reset is synchronous: all sequence state to its start value, mode to direct.
//
module ctc_greedy_decoder_unit #(
  parameter int unsigned NUM_CLASSES = ctcgd_pkg::NUM_CLASSES_DEF,
  parameter int unsigned MAX_STEPS   = ctcgd_pkg::MAX_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ctcgd_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ctcgd_pkg::out_item_t out_data
);

  // command and status between sequencer and datapath
  ctcgd_pkg::cmd_t cmd;
  ctcgd_pkg::sts_t sts;

  // Sequence the handshakes: take an input while the output slot is free or
  // emptying, run the divider at sequence end, then drop the summary in.
  ctcgd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the decoding state, update it per transaction and keep the output
  // register; a record waiting in it holds the next input until it is taken.
  ctcgd_datapath #(
    .NUM_CLASSES (NUM_CLASSES),
    .MAX_STEPS   (MAX_STEPS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_data    (out_data)
  );

endmodule

// ===== test/tb_ctc_greedy_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the CTC greedy decoder unit
// Drives score and timestep transactions in direct and argmax mode, with a
// directed table first and random sequences, mostly well-formed, after it. Every record
// is checked field by field against a cycle-free model of the decoder kept in
// the bench, or against the table record for a typed row.
// ----------------------------------------------------------------------------
module tb_ctc_greedy_decoder_unit;

  // Decoder limits at the default parameters of the unit
  localparam int unsigned POS_LAST  =
    ((ctcgd_pkg::NUM_CLASSES_DEF > 8192) ? 8192 : ctcgd_pkg::NUM_CLASSES_DEF) - 1;
  localparam int unsigned CHAR_CAP  =
    (ctcgd_pkg::MAX_STEPS_DEF > 255) ? 255 : ctcgd_pkg::MAX_STEPS_DEF;

  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned SETTLE_CYCLES = 40;   // end-of-sequence division plus margin
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned PHASE_ITEMS   = 60;
  localparam int unsigned LONG_STEPS    = 140;  // beyond the character count ceiling
  localparam int unsigned MAX_PRINTED   = 40;

  typedef enum bit {MODE_DIRECT = 1'b0, MODE_ARGMAX = 1'b1} mode_e;
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;

  typedef struct {
    mode_e                mode;
    ctcgd_pkg::in_item_t  item;
    int unsigned          reps;
    bit                   typed;  // record below is the expectation, not the decoder model
    ctcgd_pkg::out_item_t rec;
  } stim_row_t;

  localparam ctcgd_pkg::out_item_t NO_REC = '0;
  localparam int NUM_ROWS = 24;

  // Directed table. Item fields: score, class_index, end_of_step, end_of_sequence.
  // Typed records: record_kind, char_index, prob_value, char_count, overflow, last.
  stim_row_t directed_rows [NUM_ROWS] = '{
    // empty sequence straight after reset: blank dropped, mean of nothing is 0
    '{MODE_DIRECT, '{16'd0, 13'd0, 1'b0, 1'b1}, 1, 1'b1,
      '{ctcgd_pkg::REC_SUMMARY, 13'd0, 16'd0, 8'd0, 1'b0, 1'b1}},
    // top class and top probability open a fresh sequence
    '{MODE_DIRECT, '{16'd65535, 13'd8191, 1'b0, 1'b0}, 1, 1'b1,
      '{ctcgd_pkg::REC_CHAR, 13'd8191, 16'd65535, 8'd1, 1'b0, 1'b1}},
    '{MODE_DIRECT, '{16'd1234, 13'd8191, 1'b0, 1'b0}, 1, 1'b0, NO_REC},  // repeat
    '{MODE_DIRECT, '{16'd32768, 13'd0, 1'b1, 1'b0}, 1, 1'b0, NO_REC},    // blank, stray end of step
    '{MODE_DIRECT, '{16'd0, 13'd8191, 1'b0, 1'b0}, 1, 1'b0, NO_REC},     // same class after blank
    '{MODE_DIRECT, '{16'd1, 13'd1, 1'b0, 1'b1}, 1, 1'b0, NO_REC},
    '{MODE_DIRECT, '{16'd100, 13'd5, 1'b1, 1'b1}, 1, 1'b0, NO_REC},
    // argmax: ties keep the first maximum
    '{MODE_ARGMAX, '{16'd300, 13'd77, 1'b0, 1'b0}, 1, 1'b0, NO_REC},
    '{MODE_ARGMAX, '{16'd300, 13'd0, 1'b0, 1'b0}, 1, 1'b0, NO_REC},
    '{MODE_ARGMAX, '{16'd65535, 13'd0, 1'b0, 1'b0}, 1, 1'b0, NO_REC},
    '{MODE_ARGMAX, '{16'd65535, 13'd0, 1'b1, 1'b0}, 1, 1'b0, NO_REC},
    // timestep of one score only: blank
    '{MODE_ARGMAX, '{16'd7, 13'd0, 1'b1, 1'b0}, 1, 1'b0, NO_REC},
    // class 1 twice in a row: second one is a repeat
    '{MODE_ARGMAX, '{16'd0, 13'd0, 1'b0, 1'b0}, 1, 1'b0, NO_REC},
    '{MODE_ARGMAX, '{16'd9, 13'd0, 1'b1, 1'b0}, 1, 1'b0, NO_REC},
    '{MODE_ARGMAX, '{16'd0, 13'd0, 1'b0, 1'b0}, 1, 1'b0, NO_REC},
    '{MODE_ARGMAX, '{16'd9, 13'd0, 1'b1, 1'b0}, 1, 1'b0, NO_REC},
    // mode change in the middle of an open timestep
    '{MODE_ARGMAX, '{16'd50, 13'd0, 1'b0, 1'b0}, 1, 1'b0, NO_REC},
    '{MODE_DIRECT, '{16'd40, 13'd3, 1'b0, 1'b0}, 1, 1'b0, NO_REC},
    '{MODE_ARGMAX, '{16'd60, 13'd0, 1'b0, 1'b1}, 1, 1'b0, NO_REC},
    // long timestep of low scores, then a full-scale score takes the lead late
    '{MODE_ARGMAX, '{16'd10, 13'd0, 1'b0, 1'b0}, 1, 1'b0, NO_REC},
    '{MODE_ARGMAX, '{16'd20, 13'd0, 1'b0, 1'b0}, 1, 1'b0, NO_REC},
    '{MODE_ARGMAX, '{16'd5, 13'd0, 1'b0, 1'b0}, 30, 1'b0, NO_REC},
    '{MODE_ARGMAX, '{16'd65535, 13'd0, 1'b1, 1'b0}, 1, 1'b1,
      '{ctcgd_pkg::REC_CHAR, 13'd32, 16'd65535, 8'd1, 1'b0, 1'b1}},
    '{MODE_ARGMAX, '{16'd0, 13'd0, 1'b0, 1'b1}, 1, 1'b1,
      '{ctcgd_pkg::REC_SUMMARY, 13'd0, 16'd65535, 8'd1, 1'b0, 1'b1}}
  };

  // DUT inputs, all known from time zero
  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 cfg_wr_en   = 1'b0;
  logic                 cfg_wr_data = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  ctcgd_pkg::in_item_t  in_data     = '0;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  ctcgd_pkg::out_item_t out_data;

  // Decoder model state
  mode_e                         argmax_mode;
  logic [ctcgd_pkg::SCORE_W-1:0] cur_best_score;
  logic [ctcgd_pkg::CLASS_W-1:0] cur_best_class;
  logic [ctcgd_pkg::CLASS_W-1:0] cur_position;
  logic [ctcgd_pkg::CLASS_W-1:0] last_class;
  bit                            at_first_step;
  bit                            step_active;
  int unsigned                   score_total;
  int unsigned                   char_total;
  bit                            saturated;

  ctcgd_pkg::out_item_t expected_records [$];
  int unsigned error_count     = 0;
  int unsigned items_sent      = 0;
  int unsigned chars_checked   = 0;
  int unsigned summaries_checked = 0;
  int unsigned saturated_seen  = 0;
  int unsigned cycle_count     = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned recv_stall_pct  = 0;
  logic        hold_output     = 1'b0;
  event        drain_hold_ev;

  ctc_greedy_decoder_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run; the limit is several times the slowest legal run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------
  function automatic void clear_model();
    argmax_mode    = MODE_DIRECT;
    cur_best_score = '0;
    cur_best_class = '0;
    cur_position   = '0;
    last_class     = '0;
    at_first_step  = 1'b1;
    step_active    = 1'b0;
    score_total    = 0;
    char_total     = 0;
    saturated      = 1'b0;
  endfunction

  // Append one expected record at the tail of the queue
  function automatic void queue_expect(input ctcgd_pkg::out_item_t rec);
    expected_records = {expected_records, rec};
  endfunction

  // Advance the model by one accepted transaction and queue the records it causes
  function automatic void decode_item(input ctcgd_pkg::in_item_t it);
    logic [ctcgd_pkg::CLASS_W-1:0] step_class;
    logic [ctcgd_pkg::SCORE_W-1:0] step_prob;
    bit                            closed;
    bit                            dropped;
    int unsigned                   mean;
    ctcgd_pkg::out_item_t          rec;
    step_class = '0;
    step_prob  = '0;
    closed     = 1'b0;

    if (argmax_mode == MODE_ARGMAX) begin
      if (!step_active) begin
        cur_position   = '0;
        cur_best_score = it.score;
        cur_best_class = '0;
        step_active    = 1'b1;
      end else if (cur_position < POS_LAST) begin
        cur_position++;
        // strictly greater only: first maximum wins
        if (it.score > cur_best_score) begin
          cur_best_score = it.score;
          cur_best_class = cur_position;
        end
      end
      if (it.end_of_step || it.end_of_sequence) begin
        step_class     = cur_best_class;
        step_prob      = cur_best_score;
        closed         = 1'b1;
        step_active    = 1'b0;
        cur_best_score = '0;
        cur_best_class = '0;
        cur_position   = '0;
      end
    end else begin
      step_class = it.class_index;
      step_prob  = it.score;
      closed     = 1'b1;
    end

    if (closed) begin
      dropped       = (step_class == '0) || (!at_first_step && step_class == last_class);
      last_class    = step_class;
      at_first_step = 1'b0;
      if (!dropped) begin
        if (char_total >= CHAR_CAP) begin
          saturated = 1'b1;
        end else begin
          char_total++;
          score_total += 32'(step_prob);
          if (score_total > ctcgd_pkg::SUM_MAX) begin
            score_total = 32'(ctcgd_pkg::SUM_MAX);
            saturated   = 1'b1;
          end
        end
        rec.record_kind = ctcgd_pkg::REC_CHAR;
        rec.char_index  = step_class;
        rec.prob_value  = step_prob;
        rec.char_count  = ctcgd_pkg::COUNT_W'(char_total);
        rec.overflow    = saturated;
        rec.last        = !it.end_of_sequence;
        queue_expect(rec);
      end
    end

    if (it.end_of_sequence) begin
      mean = 0;
      if (char_total != 0) begin
        mean = score_total / char_total;
        if (mean > 65535) mean = 65535;
      end
      rec.record_kind = ctcgd_pkg::REC_SUMMARY;
      rec.char_index  = '0;
      rec.prob_value  = ctcgd_pkg::SCORE_W'(mean);
      rec.char_count  = ctcgd_pkg::COUNT_W'(char_total);
      rec.overflow    = saturated;
      rec.last        = 1'b1;
      queue_expect(rec);
      // drop the sequence state
      score_total   = 0;
      char_total    = 0;
      saturated     = 1'b0;
      last_class    = '0;
      at_first_step = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Compare one received record with the oldest expectation
  task automatic check_record(input ctcgd_pkg::out_item_t got);
    ctcgd_pkg::out_item_t want;
    if (expected_records.size() == 0) begin
      report_mismatch($sformatf("record with nothing expected (kind %0d index %0d prob %0d)",
                                got.record_kind, got.char_index, got.prob_value));
      return;
    end
    want = expected_records.pop_front();
    if (got.record_kind !== want.record_kind)
      report_mismatch($sformatf("record_kind %0d, want %0d", got.record_kind, want.record_kind));
    if (got.char_index !== want.char_index)
      report_mismatch($sformatf("char_index %0d, want %0d", got.char_index, want.char_index));
    if (got.prob_value !== want.prob_value)
      report_mismatch($sformatf("prob_value %0d, want %0d", got.prob_value, want.prob_value));
    if (got.char_count !== want.char_count)
      report_mismatch($sformatf("char_count %0d, want %0d", got.char_count, want.char_count));
    if (got.overflow !== want.overflow)
      report_mismatch($sformatf("overflow %0d, want %0d", got.overflow, want.overflow));
    if (got.last !== want.last)
      report_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
    if (want.record_kind == ctcgd_pkg::REC_SUMMARY) summaries_checked++;
    else chars_checked++;
    if (want.overflow) saturated_seen++;
  endtask

  // Take every output transaction at the rising edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_record(out_data);
  end

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_ready = !hold_output && ($urandom_range(99) >= recv_stall_pct);
  end

  // Hold the output for a fixed stretch so the unit fills up and stalls its input
  initial begin
    forever begin
      @(drain_hold_ev);
      hold_output = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_output = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Offer one input transaction; update the model once the unit takes it
  task automatic offer_item(input ctcgd_pkg::in_item_t it, input bit typed = 1'b0,
                            input ctcgd_pkg::out_item_t typed_rec = '0);
    int unsigned depth;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (!in_ready);
    depth = expected_records.size();
    decode_item(it);
    // a typed row replaces what the model queued for it
    if (typed) begin
      while (expected_records.size() > depth) void'(expected_records.pop_back());
      queue_expect(typed_rec);
    end
    items_sent++;
  endtask

  // Drop valid, wait for every outstanding record, then let the divider finish
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the mode register while the unit is idle
  task automatic write_mode(input mode_e mode);
    settle();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = mode;
    @(posedge clk);
    argmax_mode = mode;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  // Scores lean on the extremes and on a tiny range to force ties
  function automatic logic [ctcgd_pkg::SCORE_W-1:0] pick_score();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 50) return ctcgd_pkg::SCORE_W'($urandom_range(3));
    return ctcgd_pkg::SCORE_W'($urandom_range(65535));
  endfunction

  // Classes lean on blank and a few small values to force repeats
  function automatic logic [ctcgd_pkg::CLASS_W-1:0] pick_class();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 60) return ctcgd_pkg::CLASS_W'($urandom_range(3, 1));
    if (r < 70) return '1;
    return ctcgd_pkg::CLASS_W'($urandom_range(8191));
  endfunction

  // One well-formed sequence of timesteps in the current mode
  task automatic offer_clean_run();
    int unsigned         steps;
    int unsigned         scores;
    ctcgd_pkg::in_item_t it;
    steps = $urandom_range(10, 1);
    for (int s = 0; s < steps; s++) begin
      scores = (argmax_mode == MODE_ARGMAX) ? $urandom_range(6, 1) : 1;
      for (int k = 0; k < scores; k++) begin
        it.score           = pick_score();
        it.class_index     = (argmax_mode == MODE_ARGMAX)
                             ? ctcgd_pkg::CLASS_W'($urandom_range(8191)) : pick_class();
        it.end_of_sequence = (s == steps - 1) && (k == scores - 1);
        if (argmax_mode == MODE_DIRECT || it.end_of_sequence)
          it.end_of_step = 1'($urandom_range(1));
        else
          it.end_of_step = (k == scores - 1);
        offer_item(it);
      end
    end
  endtask

  // Direct sequence longer than the count ceiling, every class distinct from the last
  task automatic offer_long_run();
    ctcgd_pkg::in_item_t           it;
    logic [ctcgd_pkg::CLASS_W-1:0] prev;
    prev = '0;
    for (int s = 0; s < LONG_STEPS; s++) begin
      do it.class_index = ctcgd_pkg::CLASS_W'($urandom_range(8191, 1));
      while (it.class_index == prev);
      prev               = it.class_index;
      it.score           = ctcgd_pkg::SCORE_W'($urandom_range(65535));
      it.end_of_step     = 1'($urandom_range(1));
      it.end_of_sequence = (s == LONG_STEPS - 1);
      offer_item(it);
    end
  endtask

  // A few unstructured transactions: broken timesteps and stray markers
  task automatic offer_noise();
    ctcgd_pkg::in_item_t it;
    int unsigned         n;
    n = $urandom_range(8, 1);
    repeat (n) begin
      it.score           = ctcgd_pkg::SCORE_W'($urandom_range(65535));
      it.class_index     = ctcgd_pkg::CLASS_W'($urandom_range(8191));
      it.end_of_step     = 1'($urandom_range(1));
      it.end_of_sequence = ($urandom_range(4) == 0);
      offer_item(it);
    end
  endtask

  task automatic run_phase(input mode_e mode, input idle_e idle, input bit with_long,
                           input bit with_hold);
    int unsigned start;
    write_mode(mode);
    case (idle)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 59; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 59; end
      default:   begin send_idle_pct = 7;  recv_stall_pct = 7;  end
    endcase
    if (with_hold) -> drain_hold_ev;
    if (with_long) offer_long_run();
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS) begin
      if ($urandom_range(99) < 85) offer_clean_run();
      else offer_noise();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table, no idling; write the reset mode once to cover that value
    write_mode(MODE_DIRECT);
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (directed_rows[r].mode != argmax_mode) write_mode(directed_rows[r].mode);
      for (int k = 0; k < directed_rows[r].reps; k++)
        offer_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].rec);
    end

    // Random part: both modes under every idle pattern
    run_phase(MODE_DIRECT, IDLE_NONE, 1'b1, 1'b1);
    run_phase(MODE_ARGMAX, IDLE_SEND, 1'b0, 1'b0);
    run_phase(MODE_DIRECT, IDLE_RECV, 1'b0, 1'b0);
    run_phase(MODE_ARGMAX, IDLE_BOTH, 1'b0, 1'b0);
    run_phase(MODE_ARGMAX, IDLE_NONE, 1'b0, 1'b0);
    run_phase(MODE_DIRECT, IDLE_SEND, 1'b1, 1'b0);
    run_phase(MODE_ARGMAX, IDLE_RECV, 1'b0, 1'b0);
    run_phase(MODE_DIRECT, IDLE_BOTH, 1'b0, 1'b0);

    settle();

    $display("Run covered %0d input transactions in direct and argmax mode, four idle",
             items_sent);
    $display("patterns and a long output hold-off: %0d characters, %0d summaries, %0d saturated.",
             chars_checked, summaries_checked, saturated_seen);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
